// File: design/i2c_master_byte_engine_defines.svh
// assertion helpers shared by the i2c master engine modules
`ifndef I2C_MASTER_BYTE_ENGINE_DEFINES_SVH
`define I2C_MASTER_BYTE_ENGINE_DEFINES_SVH

// plain property sampled on clk, off during reset
`define I2CM_ASSERT(label, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// implication: cons must hold in the same cycle as ante
`define I2CM_ASSERT_IMPL(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// implication: cons must hold in the cycle after ante
`define I2CM_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// File: design/i2cm_pkg.sv
package i2cm_pkg;

    localparam logic [7:0] PHASE_TICKS_RESET = 8'd1;
    localparam int         QUEUE_DEPTH_DEF   = 2;

    typedef enum logic {
        KIND_CMD  = 1'b0,
        KIND_TICK = 1'b1
    } kind_t;

    typedef enum logic [1:0] {
        CMD_START = 2'd0,
        CMD_STOP  = 2'd1,
        CMD_WRITE = 2'd2,
        CMD_READ  = 2'd3
    } cmd_t;

    typedef enum logic [1:0] {
        ACK_NACK = 2'd0,
        ACK_ACK  = 2'd1,
        ACK_NONE = 2'd2
    } ack_t;

    typedef enum logic [4:0] {
        PH_IDLE  = 5'd0,
        PH_ST0   = 5'd1,
        PH_ST1   = 5'd2,
        PH_ST2   = 5'd3,
        PH_SP0   = 5'd4,
        PH_SP1   = 5'd5,
        PH_SP2   = 5'd6,
        PH_SP3   = 5'd7,
        PH_WBIT  = 5'd8,
        PH_WHIGH = 5'd9,
        PH_WACKL = 5'd10,
        PH_WACKH = 5'd11,
        PH_WEND  = 5'd12,
        PH_RBEG  = 5'd13,
        PH_RHIGH = 5'd14,
        PH_RSAMP = 5'd15,
        PH_RACKH = 5'd16,
        PH_REND  = 5'd17
    } phase_t;

    typedef struct packed {
        logic       kind;
        logic [1:0] command;
        logic [7:0] tx_byte;
        logic [1:0] ack_mode;
        logic       sda_in;
    } in_item_t;

    typedef struct packed {
        logic       scl_level;
        logic       sda_pull_low;
        logic       done_res;
        logic [7:0] rx_byte;
        logic       ack_missing;
        logic       busy_res;
    } out_item_t;

    // decoded item as it sits in the queue
    typedef struct packed {
        logic       is_tick;
        cmd_t       command;
        phase_t     first_phase;
        logic       load_shift;
        logic [7:0] shift_init;
        ack_t       ack_mode;
        logic       sda_in;
    } op_t;

endpackage

// File: design/i2cm_front.sv
module i2cm_front
(
    input  logic               req_valid,
    output logic               req_ready,
    input  i2cm_pkg::in_item_t req,
    input  logic               q_ready,
    output logic               push,
    output i2cm_pkg::op_t      op
);

    assign req_ready = q_ready;
    assign push      = req_valid && q_ready;

    always_comb
    begin
        op.is_tick    = (i2cm_pkg::kind_t'(req.kind) == i2cm_pkg::KIND_TICK);
        op.command    = i2cm_pkg::cmd_t'(req.command);
        op.sda_in     = req.sda_in;
        op.load_shift = 1'b0;
        op.shift_init = req.tx_byte;
        case (i2cm_pkg::cmd_t'(req.command))
            i2cm_pkg::CMD_START: op.first_phase = i2cm_pkg::PH_ST0;
            i2cm_pkg::CMD_STOP:  op.first_phase = i2cm_pkg::PH_SP0;
            i2cm_pkg::CMD_WRITE:
            begin
                op.first_phase = i2cm_pkg::PH_WBIT;
                op.load_shift  = 1'b1;
            end
            default:
            begin
                op.first_phase = i2cm_pkg::PH_RBEG;
                op.load_shift  = 1'b1;
                op.shift_init  = 8'd0;
            end
        endcase
        // undefined ack code means send nothing
        case (i2cm_pkg::ack_t'(req.ack_mode))
            i2cm_pkg::ACK_NACK: op.ack_mode = i2cm_pkg::ACK_NACK;
            i2cm_pkg::ACK_ACK:  op.ack_mode = i2cm_pkg::ACK_ACK;
            default:            op.ack_mode = i2cm_pkg::ACK_NONE;
        endcase
    end

endmodule

// File: design/i2cm_queue.sv
`include "i2c_master_byte_engine_defines.svh"

module i2cm_queue
#(
    parameter int DEPTH = i2cm_pkg::QUEUE_DEPTH_DEF
)
(
    input  logic          clk,
    input  logic          rst_n,
    input  logic          push,
    input  i2cm_pkg::op_t push_op,
    output logic          q_ready,
    input  logic          pop,
    output logic          q_valid,
    output i2cm_pkg::op_t head_op
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    i2cm_pkg::op_t    mem [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] count_reg, count_next;

    assign q_ready = (count_reg != CNT_W'(DEPTH));
    assign q_valid = (count_reg != '0);
    assign head_op = mem[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
        begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + PTR_W'(1);
        end
        if (pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + PTR_W'(1);
        end
        if (push && !pop)
        begin
            count_next = count_reg + CNT_W'(1);
        end
        else if (pop && !push)
        begin
            count_next = count_reg - CNT_W'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem[wr_ptr_reg] <= push_op;
        end
    end

    `I2CM_ASSERT(a_count_bound, count_reg <= CNT_W'(DEPTH), "queue count beyond depth")
    `I2CM_ASSERT_NEXT(a_count_grows, push && !pop, count_reg == $past(count_reg) + CNT_W'(1), "queue count did not grow on push")

endmodule

// File: design/i2cm_seq.sv
`include "i2c_master_byte_engine_defines.svh"

module i2cm_seq
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                cfg_valid,
    input  logic [7:0]          cfg_data,
    input  logic                q_valid,
    input  i2cm_pkg::op_t       op,
    output logic                pop,
    output logic                rsp_valid,
    input  logic                rsp_ready,
    output i2cm_pkg::out_item_t rsp
);

    logic [7:0]          phase_ticks_reg;
    i2cm_pkg::phase_t    phase_reg, phase_next;
    logic [3:0]          bit_count_reg, bit_count_next;
    logic [7:0]          shift_reg, shift_next;
    logic [7:0]          tick_count_reg, tick_count_next;
    i2cm_pkg::cmd_t      active_cmd_reg, active_cmd_next;
    i2cm_pkg::ack_t      ack_mode_reg, ack_mode_next;
    logic                scl_reg, scl_next;
    logic                sda_reg, sda_next;
    logic                rsp_valid_reg, rsp_valid_next;
    i2cm_pkg::out_item_t rsp_reg, rsp_next;

    logic       busy;
    logic       done;
    logic       nack;
    logic [7:0] rx;
    logic [7:0] limit;

    assign busy      = (phase_reg != i2cm_pkg::PH_IDLE);
    assign limit     = (phase_ticks_reg == 8'd0) ? 8'd1 : phase_ticks_reg;
    // a command never waits on the result side
    assign pop       = q_valid && (!op.is_tick || !rsp_valid_reg || rsp_ready);
    assign rsp_valid = rsp_valid_reg;
    assign rsp       = rsp_reg;

    always_comb
    begin
        phase_next      = phase_reg;
        bit_count_next  = bit_count_reg;
        shift_next      = shift_reg;
        tick_count_next = tick_count_reg;
        active_cmd_next = active_cmd_reg;
        ack_mode_next   = ack_mode_reg;
        scl_next        = scl_reg;
        sda_next        = sda_reg;
        done            = 1'b0;
        nack            = 1'b0;
        rx              = 8'd0;

        if (pop && !op.is_tick)
        begin
            // commands that arrive while busy are dropped
            if (!busy)
            begin
                active_cmd_next = op.command;
                ack_mode_next   = op.ack_mode;
                tick_count_next = 8'd0;
                bit_count_next  = 4'd0;
                phase_next      = op.first_phase;
                if (op.load_shift)
                begin
                    shift_next = op.shift_init;
                end
            end
        end
        else if (pop && busy)
        begin
            if (({1'b0, tick_count_reg} + 9'd1) < {1'b0, limit})
            begin
                tick_count_next = tick_count_reg + 8'd1;
            end
            else
            begin
                tick_count_next = 8'd0;
                case (phase_reg)
                    i2cm_pkg::PH_ST0:
                    begin
                        sda_next   = 1'b1;
                        scl_next   = 1'b1;
                        phase_next = i2cm_pkg::PH_ST1;
                    end
                    i2cm_pkg::PH_ST1:
                    begin
                        sda_next   = 1'b0;
                        phase_next = i2cm_pkg::PH_ST2;
                    end
                    i2cm_pkg::PH_ST2:
                    begin
                        scl_next = 1'b0;
                        done     = 1'b1;
                    end
                    i2cm_pkg::PH_SP0:
                    begin
                        scl_next   = 1'b0;
                        phase_next = i2cm_pkg::PH_SP1;
                    end
                    i2cm_pkg::PH_SP1:
                    begin
                        sda_next   = 1'b0;
                        phase_next = i2cm_pkg::PH_SP2;
                    end
                    i2cm_pkg::PH_SP2:
                    begin
                        scl_next   = 1'b1;
                        phase_next = i2cm_pkg::PH_SP3;
                    end
                    i2cm_pkg::PH_SP3:
                    begin
                        sda_next = 1'b1;
                        done     = 1'b1;
                    end
                    i2cm_pkg::PH_WBIT:
                    begin
                        scl_next   = 1'b0;
                        sda_next   = shift_reg[7];
                        shift_next = {shift_reg[6:0], 1'b0};
                        phase_next = i2cm_pkg::PH_WHIGH;
                    end
                    i2cm_pkg::PH_WHIGH:
                    begin
                        scl_next       = 1'b1;
                        bit_count_next = bit_count_reg + 4'd1;
                        phase_next     = (bit_count_next >= 4'd8) ? i2cm_pkg::PH_WACKL
                                                                  : i2cm_pkg::PH_WBIT;
                    end
                    i2cm_pkg::PH_WACKL:
                    begin
                        scl_next   = 1'b0;
                        sda_next   = 1'b1;
                        phase_next = i2cm_pkg::PH_WACKH;
                    end
                    i2cm_pkg::PH_WACKH:
                    begin
                        scl_next   = 1'b1;
                        phase_next = i2cm_pkg::PH_WEND;
                    end
                    i2cm_pkg::PH_WEND:
                    begin
                        nack     = op.sda_in;
                        scl_next = 1'b0;
                        done     = 1'b1;
                    end
                    i2cm_pkg::PH_RBEG:
                    begin
                        scl_next   = 1'b0;
                        sda_next   = 1'b1;
                        phase_next = i2cm_pkg::PH_RHIGH;
                    end
                    i2cm_pkg::PH_RHIGH:
                    begin
                        scl_next   = 1'b1;
                        phase_next = i2cm_pkg::PH_RSAMP;
                    end
                    i2cm_pkg::PH_RSAMP:
                    begin
                        shift_next     = {shift_reg[6:0], op.sda_in};
                        bit_count_next = bit_count_reg + 4'd1;
                        scl_next       = 1'b0;
                        if (bit_count_next < 4'd8)
                        begin
                            phase_next = i2cm_pkg::PH_RHIGH;
                        end
                        else if (ack_mode_reg != i2cm_pkg::ACK_NONE)
                        begin
                            sda_next   = (ack_mode_reg != i2cm_pkg::ACK_ACK);
                            phase_next = i2cm_pkg::PH_RACKH;
                        end
                        else
                        begin
                            done = 1'b1;
                        end
                    end
                    i2cm_pkg::PH_RACKH:
                    begin
                        scl_next   = 1'b1;
                        phase_next = i2cm_pkg::PH_REND;
                    end
                    default:
                    begin
                        scl_next = 1'b0;
                        done     = 1'b1;
                    end
                endcase
                if (done)
                begin
                    if (active_cmd_reg == i2cm_pkg::CMD_READ)
                    begin
                        rx = shift_next;
                    end
                    phase_next = i2cm_pkg::PH_IDLE;
                end
            end
        end

        // result slot: load on every tick, drain when taken
        rsp_valid_next = rsp_valid_reg && !rsp_ready;
        rsp_next       = rsp_reg;
        if (pop && op.is_tick)
        begin
            rsp_valid_next        = 1'b1;
            rsp_next.scl_level    = scl_next;
            rsp_next.sda_pull_low = !sda_next;
            rsp_next.done_res     = done;
            rsp_next.rx_byte      = rx;
            rsp_next.ack_missing  = nack;
            rsp_next.busy_res     = (phase_next != i2cm_pkg::PH_IDLE);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_ticks_reg <= i2cm_pkg::PHASE_TICKS_RESET;
            phase_reg       <= i2cm_pkg::PH_IDLE;
            bit_count_reg   <= 4'd0;
            shift_reg       <= 8'd0;
            tick_count_reg  <= 8'd0;
            active_cmd_reg  <= i2cm_pkg::CMD_START;
            ack_mode_reg    <= i2cm_pkg::ACK_NACK;
            scl_reg         <= 1'b1;
            sda_reg         <= 1'b1;
            rsp_valid_reg   <= 1'b0;
        end
        else
        begin
            if (cfg_valid)
            begin
                phase_ticks_reg <= cfg_data;
            end
            phase_reg      <= phase_next;
            bit_count_reg  <= bit_count_next;
            shift_reg      <= shift_next;
            tick_count_reg <= tick_count_next;
            active_cmd_reg <= active_cmd_next;
            ack_mode_reg   <= ack_mode_next;
            scl_reg        <= scl_next;
            sda_reg        <= sda_next;
            rsp_valid_reg  <= rsp_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rsp_reg <= rsp_next;
    end

    `I2CM_ASSERT(a_bit_count_bound, bit_count_reg <= 4'd8, "bit count past eight")
    `I2CM_ASSERT_NEXT(a_cmd_starts, pop && !op.is_tick && !busy, busy, "accepted command did not start")
    `I2CM_ASSERT_IMPL(a_rx_only_done, rsp_valid_reg && !rsp_reg.done_res, rsp_reg.rx_byte == 8'd0 && !rsp_reg.ack_missing, "read data or nack outside done")
    `I2CM_ASSERT_IMPL(a_done_not_busy, rsp_valid_reg && rsp_reg.done_res, !rsp_reg.busy_res, "done item still reports busy")

endmodule

// File: design/i2c_master_byte_engine.sv
// I2C master byte engine. Items on req are either commands (start, stop, write byte, read byte)
// or bus ticks carrying the sampled SDA level; every tick returns exactly one item on rsp with
// the SCL and SDA drive, a done flag, the read byte and the write acknowledge status, while
// commands return nothing and are dropped when one is already in progress. One item is taken
// per clock while the queue has room: the front decodes it into a small queue and the bus
// sequencer retires one queued item per clock into a result register (a tick only when the
// register is free or taken), so a tick's result passes the queue and the result register
// before it is offered on rsp. The SCL rate is set by cfg_data, the number of ticks per bus
// phase (zero acts as one); write it only while the engine is idle. cfg_ready is always high.
module i2c_master_byte_engine
#(
    parameter int QUEUE_DEPTH = i2cm_pkg::QUEUE_DEPTH_DEF
)
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                req_valid,
    output logic                req_ready,
    input  i2cm_pkg::in_item_t  req,
    output logic                rsp_valid,
    input  logic                rsp_ready,
    output i2cm_pkg::out_item_t rsp,
    input  logic                cfg_valid,
    output logic                cfg_ready,
    input  logic [7:0]          cfg_data
);

    logic          q_ready;
    logic          push;
    logic          pop;
    logic          q_valid;
    i2cm_pkg::op_t push_op;
    i2cm_pkg::op_t head_op;

    assign cfg_ready = 1'b1;

    i2cm_front u_front
    (
        .req_valid (req_valid),
        .req_ready (req_ready),
        .req       (req),
        .q_ready   (q_ready),
        .push      (push),
        .op        (push_op)
    );

    i2cm_queue
    #(
        .DEPTH (QUEUE_DEPTH)
    )
    u_queue
    (
        .clk     (clk),
        .rst_n   (rst_n),
        .push    (push),
        .push_op (push_op),
        .q_ready (q_ready),
        .pop     (pop),
        .q_valid (q_valid),
        .head_op (head_op)
    );

    i2cm_seq u_seq
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_valid (cfg_valid),
        .cfg_data  (cfg_data),
        .q_valid   (q_valid),
        .op        (head_op),
        .pop       (pop),
        .rsp_valid (rsp_valid),
        .rsp_ready (rsp_ready),
        .rsp       (rsp)
    );

endmodule
